>>> hdl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared widths, codes and control types of the size class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    // default configuration
    localparam int NUM_CLASSES_DEF     = 6;
    localparam int UNITS_PER_CLASS_DEF = 1024;
    localparam int SIZE_BITS_DEF       = 16;

    // fixed port widths
    localparam int SIZE_W    = 16;
    localparam int CLASS_W   = 3;
    localparam int UNIT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;

    // number of size registers on the configuration port
    localparam int CFG_COUNT = 6;

    // block size of class 0 after reset, doubling per class
    localparam int BASE_CLASS_SIZE = 16;

    // request mode
    localparam logic MODE_ALLOC = 1'b0;

    // class number that marks a block taken from system memory
    localparam logic [CLASS_W-1:0] SYS_CLASS = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SYSTEM    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SYS_BLOCK = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_CLASS = 3'd5;

    // decoded operation held between lookup and commit
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FALLBACK,
        OP_FREE,
        OP_SYS_BLOCK,
        OP_BAD_CLASS
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } scpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } scpa_stat_t;

endpackage

>>> hdl/scpa_ctrl.sv
// ----------------------------------------------------------------------------
// scpa_ctrl
// Sequencer of the allocator: clearing pass, lookup, commit and result hold.
// ----------------------------------------------------------------------------
module scpa_ctrl
    import scpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  scpa_stat_t stat,
    output scpa_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // commands to the datapath
    always_comb
    begin
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.capture    = (state_reg == S_IDLE) && in_valid;
        cmd.commit     = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (stat.clear_last)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (cmd.commit)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction taken before commit");

    // a commit always presents a result
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit without output valid");

    // no result can exist during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result pending during clearing pass");

endmodule

>>> hdl/scpa_datapath.sv
// ----------------------------------------------------------------------------
// scpa_datapath
// Size registers, free list pointers and counts, free list and used bit
// memories, class search and result register.
// ----------------------------------------------------------------------------
module scpa_datapath
    import scpa_pkg::*;
#(
    parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
    parameter int UNITS_PER_CLASS = UNITS_PER_CLASS_DEF,
    parameter int SIZE_BITS       = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scpa_cmd_t             cmd,
    output scpa_stat_t            stat,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  mode,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [CLASS_W-1:0]    free_class,
    input  logic [UNIT_W-1:0]     free_unit,
    output logic [STATUS_W-1:0]   status,
    output logic [CLASS_W-1:0]    grant_class,
    output logic [UNIT_W-1:0]     grant_unit,
    output logic [COUNT_W-1:0]    class_free_count
);

    localparam int SZ_W   = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
    localparam int PTR_W  = $clog2(UNITS_PER_CLASS);
    localparam int CNT_W  = $clog2(UNITS_PER_CLASS + 1);
    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int DEPTH  = NUM_CLASSES << PTR_W;
    localparam int ADDR_W = $clog2(DEPTH);

    // per-class control state
    logic [SZ_W-1:0]  size_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg  [NUM_CLASSES];
    logic [CNT_W-1:0] count_reg [NUM_CLASSES];
    logic             wrap_reg  [NUM_CLASSES];
    logic [ADDR_W-1:0] clr_cnt_reg;
    op_t              op_reg;

    // lookup results held until commit
    logic [CLASS_W-1:0] cls_reg;
    logic [CIDX_W-1:0]  cidx_reg;
    logic [PTR_W-1:0]   slot_reg;
    logic               slot_wr_reg;
    logic [PTR_W-1:0]   unit_reg;

    // memories
    logic [PTR_W-1:0] store_mem [DEPTH];
    logic             used_mem  [DEPTH];
    logic [PTR_W-1:0] store_rd_reg;
    logic             used_rd_reg;

    // result register
    logic [STATUS_W-1:0] status_reg;
    logic [CLASS_W-1:0]  grant_class_reg;
    logic [UNIT_W-1:0]   grant_unit_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    // lookup side
    logic [SZ_W-1:0]   req_size;
    logic              alloc_hit;
    logic [CIDX_W-1:0] alloc_sel;
    logic              free_bad;
    logic [CIDX_W-1:0] free_cidx;
    logic [PTR_W-1:0]  free_ptr;
    logic [PTR_W-1:0]  head_sel;
    logic [ADDR_W-1:0] store_raddr;
    logic [ADDR_W-1:0] used_raddr;

    // commit side
    logic [PTR_W-1:0]    alloc_unit;
    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W-1:0]    cnt_inc;
    logic [PTR_W-1:0]    head_cur;
    logic [PTR_W-1:0]    tail_cur;
    logic                used_we;
    logic                used_wdata;
    logic [ADDR_W-1:0]   used_waddr;
    logic                store_we;
    logic [ADDR_W-1:0]   store_waddr;
    logic [STATUS_W-1:0] res_status;
    logic [CLASS_W-1:0]  res_class;
    logic [UNIT_W-1:0]   res_unit;
    logic [COUNT_W-1:0]  res_count;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(UNITS_PER_CLASS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CIDX_W-1:0] c,
                                                   input logic [PTR_W-1:0]  p);
        return ADDR_W'({c, p});
    endfunction

    // first fitting class with a free unit, lowest index wins
    always_comb
    begin
        req_size  = SZ_W'(request_size);
        alloc_hit = 1'b0;
        alloc_sel = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if ((req_size <= size_reg[c]) && (count_reg[c] != '0))
            begin
                alloc_hit = 1'b1;
                alloc_sel = CIDX_W'(c);
            end
        end
    end

    // free handle check and read addresses
    always_comb
    begin
        free_bad    = (32'(free_class) >= NUM_CLASSES) ||
                      (32'(free_unit) >= UNITS_PER_CLASS);
        free_cidx   = CIDX_W'(free_class);
        free_ptr    = PTR_W'(free_unit);
        head_sel    = head_reg[alloc_sel];
        store_raddr = mem_addr(alloc_sel, head_sel);
        used_raddr  = mem_addr(free_cidx, free_ptr);
    end

    // commit: memory writes and result
    always_comb
    begin
        alloc_unit  = slot_wr_reg ? store_rd_reg : slot_reg;
        cnt_cur     = count_reg[cidx_reg];
        cnt_inc     = (cnt_cur < CNT_W'(UNITS_PER_CLASS)) ? cnt_cur + 1'b1 : cnt_cur;
        head_cur    = head_reg[cidx_reg];
        tail_cur    = tail_reg[cidx_reg];
        used_we     = 1'b0;
        used_wdata  = 1'b0;
        used_waddr  = mem_addr(cidx_reg, unit_reg);
        store_we    = 1'b0;
        store_waddr = mem_addr(cidx_reg, tail_cur);
        res_status  = ST_SYSTEM;
        res_class   = SYS_CLASS;
        res_unit    = '0;
        res_count   = '0;
        case (op_reg)
            OP_ALLOC:
            begin
                used_we    = cmd.commit;
                used_wdata = 1'b1;
                used_waddr = mem_addr(cidx_reg, alloc_unit);
                res_status = ST_GRANTED;
                res_class  = cls_reg;
                res_unit   = UNIT_W'(alloc_unit);
                res_count  = COUNT_W'(cnt_cur - 1'b1);
            end
            OP_FREE:
            begin
                res_class = cls_reg;
                if (used_rd_reg)
                begin
                    used_we    = cmd.commit;
                    store_we   = cmd.commit;
                    res_status = ST_FREED;
                    res_count  = COUNT_W'(cnt_inc);
                end
                else
                begin
                    res_status = ST_DOUBLE;
                    res_count  = COUNT_W'(cnt_cur);
                end
            end
            OP_SYS_BLOCK:
            begin
                res_status = ST_SYS_BLOCK;
            end
            OP_BAD_CLASS:
            begin
                res_status = ST_BAD_CLASS;
                res_class  = cls_reg;
            end
            default:
            begin
                res_status = ST_SYSTEM;
            end
        endcase
    end

    // size registers, pointers, counts and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                size_reg[c]  <= SZ_W'(32'(BASE_CLASS_SIZE) << c);
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= CNT_W'(UNITS_PER_CLASS);
                wrap_reg[c]  <= 1'b0;
            end
            clr_cnt_reg <= '0;
            op_reg      <= OP_FALLBACK;
        end
        else
        begin
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (cfg_wr && (32'(cfg_index) < CFG_COUNT) && (32'(cfg_index) < NUM_CLASSES))
                size_reg[CIDX_W'(cfg_index)] <= SZ_W'(cfg_data);

            // decode at lookup
            if (cmd.capture)
            begin
                if (mode == MODE_ALLOC)
                    op_reg <= alloc_hit ? OP_ALLOC : OP_FALLBACK;
                else if (free_class == SYS_CLASS)
                    op_reg <= OP_SYS_BLOCK;
                else if (free_bad)
                    op_reg <= OP_BAD_CLASS;
                else
                    op_reg <= OP_FREE;
            end

            // list pointer and count update at commit
            if (cmd.commit)
            begin
                if (op_reg == OP_ALLOC)
                begin
                    head_reg[cidx_reg]  <= wrap_next(head_cur);
                    count_reg[cidx_reg] <= cnt_cur - 1'b1;
                end
                else if ((op_reg == OP_FREE) && used_rd_reg)
                begin
                    tail_reg[cidx_reg]  <= wrap_next(tail_cur);
                    count_reg[cidx_reg] <= cnt_inc;
                    if (tail_cur == PTR_W'(UNITS_PER_CLASS - 1))
                        wrap_reg[cidx_reg] <= 1'b1;
                end
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    // lookup payload and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (mode == MODE_ALLOC)
            begin
                cls_reg  <= CLASS_W'(alloc_sel);
                cidx_reg <= alloc_sel;
            end
            else
            begin
                cls_reg  <= free_class;
                cidx_reg <= free_cidx;
            end
            slot_reg    <= head_sel;
            // a slot holds its own index until the tail first passes it
            slot_wr_reg <= wrap_reg[alloc_sel] || (head_sel < tail_reg[alloc_sel]);
            unit_reg    <= free_ptr;
        end
        if (cmd.commit)
        begin
            status_reg      <= res_status;
            grant_class_reg <= res_class;
            grant_unit_reg  <= res_unit;
            count_out_reg   <= res_count;
        end
    end

    // free list memory
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= unit_reg;
        if (cmd.capture)
            store_rd_reg <= store_mem[store_raddr];
    end

    // used bit memory, swept to zero after reset
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            used_mem[clr_cnt_reg] <= 1'b0;
        else if (used_we)
            used_mem[used_waddr] <= used_wdata;
        if (cmd.capture)
            used_rd_reg <= used_mem[used_raddr];
    end

    assign status           = status_reg;
    assign grant_class      = grant_class_reg;
    assign grant_unit       = grant_unit_reg;
    assign class_free_count = count_out_reg;

    // the search only picks a class that has a unit left
    a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == OP_ALLOC)) |-> (cnt_cur != '0))
        else $error("allocation from an empty class");

    // a unit marked used is never on its list, so the list cannot be full
    a_free_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == OP_FREE) && used_rd_reg) |->
        (cnt_cur < CNT_W'(UNITS_PER_CLASS)))
        else $error("used unit freed into a full list");

endmodule

>>> hdl/size_class_pool_allocator.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator
// Fixed-block allocator with first-fit size classes and FIFO free lists.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    mode, request_size, free_class,
//                                              free_unit
//   out      source     out_valid / out_ready  status, grant_class, grant_unit,
//                                              class_free_count
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each transaction searches the classes and reads the free list and used bit
// memories at lookup, then writes them back and loads the result at commit.
// The next transaction is taken while a result waits; its commit waits for the
// output register to empty.
// After reset the used bit memory is swept, all NUM_CLASSES * 2**ceil(log2(
// UNITS_PER_CLASS)) entries (6144 by default), with in_ready low.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module size_class_pool_allocator
    import scpa_pkg::*;
#(
    parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
    parameter int UNITS_PER_CLASS = UNITS_PER_CLASS_DEF,
    parameter int SIZE_BITS       = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [CLASS_W-1:0]    free_class,
    input  logic [UNIT_W-1:0]     free_unit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [CLASS_W-1:0]    grant_class,
    output logic [UNIT_W-1:0]     grant_unit,
    output logic [COUNT_W-1:0]    class_free_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data
);

    scpa_cmd_t  cmd;
    scpa_stat_t stat;

    // configuration writes are taken every cycle
    assign cfg_ready = 1'b1;

    // sequencer
    scpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // lists, memories and result
    scpa_datapath #(
        .NUM_CLASSES     (NUM_CLASSES),
        .UNITS_PER_CLASS (UNITS_PER_CLASS),
        .SIZE_BITS       (SIZE_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .request_size     (request_size),
        .free_class       (free_class),
        .free_unit        (free_unit),
        .status           (status),
        .grant_class      (grant_class),
        .grant_unit       (grant_unit),
        .class_free_count (class_free_count)
    );

endmodule

>>> tb/alloc_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_check_pkg
// Transaction types and the scoreboard of the size class pool allocator
// testbench. The scoreboard keeps its own copy of the class sizes, the free
// lists and the used bits, works out the result of each accepted request and
// compares the results of the block against them in order.
// ----------------------------------------------------------------------------
package alloc_check_pkg;

    import scpa_pkg::*;

    localparam int   POOL_CLASSES = NUM_CLASSES_DEF;
    localparam int   POOL_UNITS   = UNITS_PER_CLASS_DEF;
    localparam logic MODE_FREE    = ~MODE_ALLOC;
    localparam int   REPORT_LIMIT = 40;

    // one request on the input channel
    typedef struct packed {
        logic                mode;
        logic [SIZE_W-1:0]   request_size;
        logic [CLASS_W-1:0]  free_class;
        logic [UNIT_W-1:0]   free_unit;
    } alloc_req_t;

    // one result on the output channel
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  grant_class;
        logic [UNIT_W-1:0]   grant_unit;
        logic [COUNT_W-1:0]  class_free_count;
    } alloc_result_t;

    // a block handed out by the pool
    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [UNIT_W-1:0]   unit;
    } block_handle_t;

    class pool_scoreboard;

        logic [SIZE_W-1:0]  block_size [POOL_CLASSES];
        logic [UNIT_W-1:0]  slot_unit  [POOL_CLASSES][POOL_UNITS];
        int                 pop_slot   [POOL_CLASSES];
        int                 push_slot  [POOL_CLASSES];
        logic [COUNT_W-1:0] units_left [POOL_CLASSES];
        bit                 in_use     [POOL_CLASSES][POOL_UNITS];
        alloc_result_t      awaited_q[$];
        int                 errors;

        // state after reset: every list holds its units in order
        function new();
            errors = 0;
            for (int c = 0; c < POOL_CLASSES; c++)
            begin
                block_size[c] = SIZE_W'(BASE_CLASS_SIZE << c);
                pop_slot[c]   = 0;
                push_slot[c]  = 0;
                units_left[c] = COUNT_W'(POOL_UNITS);
                for (int i = 0; i < POOL_UNITS; i++)
                begin
                    slot_unit[c][i] = UNIT_W'(i);
                    in_use[c][i]    = 1'b0;
                end
            end
        endfunction

        function int next_slot(int s);
            return (s + 1 >= POOL_UNITS) ? 0 : s + 1;
        endfunction

        function alloc_result_t make_result(logic [STATUS_W-1:0] st,
                                            logic [CLASS_W-1:0] cls,
                                            logic [UNIT_W-1:0] unit,
                                            logic [COUNT_W-1:0] cnt);
            alloc_result_t r;
            r.status           = st;
            r.grant_class      = cls;
            r.grant_unit       = unit;
            r.class_free_count = cnt;
            return r;
        endfunction

        // register write; spare indexes are dropped
        function void set_size(int idx, logic [SIZE_W-1:0] value);
            if (idx < CFG_COUNT && idx < POOL_CLASSES)
                block_size[idx] = value;
        endfunction

        // predict the result of one accepted request and queue it
        function alloc_result_t note(alloc_req_t req);
            alloc_result_t     res;
            int                fc;
            bit                placed;
            logic [UNIT_W-1:0] unit;
            res    = make_result(ST_SYSTEM, SYS_CLASS, '0, '0);
            fc     = int'(req.free_class);
            placed = 1'b0;
            if (req.mode == MODE_ALLOC)
            begin
                // first fit in class order, skipping empty classes
                for (int c = 0; c < POOL_CLASSES; c++)
                begin
                    if (!placed && req.request_size <= block_size[c] && units_left[c] != 0)
                    begin
                        unit          = slot_unit[c][pop_slot[c]];
                        pop_slot[c]   = next_slot(pop_slot[c]);
                        units_left[c] = units_left[c] - 1'b1;
                        in_use[c][unit] = 1'b1;
                        res    = make_result(ST_GRANTED, CLASS_W'(c), unit, units_left[c]);
                        placed = 1'b1;
                    end
                end
            end
            else if (req.free_class == SYS_CLASS)
                res = make_result(ST_SYS_BLOCK, SYS_CLASS, '0, '0);
            else if (fc >= POOL_CLASSES || int'(req.free_unit) >= POOL_UNITS)
                res = make_result(ST_BAD_CLASS, req.free_class, '0, '0);
            else if (!in_use[fc][req.free_unit])
                res = make_result(ST_DOUBLE, req.free_class, '0, units_left[fc]);
            else
            begin
                // push the unit back on the tail of its list
                in_use[fc][req.free_unit]     = 1'b0;
                slot_unit[fc][push_slot[fc]] = req.free_unit;
                push_slot[fc]                = next_slot(push_slot[fc]);
                if (units_left[fc] < POOL_UNITS)
                    units_left[fc] = units_left[fc] + 1'b1;
                res = make_result(ST_FREED, req.free_class, '0, units_left[fc]);
            end
            awaited_q.push_back(res);
            return res;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        endtask

        // compare one accepted result with the oldest prediction
        task check(alloc_result_t got);
            alloc_result_t want;
            if (awaited_q.size() == 0)
            begin
                report("unexpected result, status", got.status, 0);
                return;
            end
            want = awaited_q.pop_front();
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.grant_class != want.grant_class)
                report("grant_class", got.grant_class, want.grant_class);
            if (got.grant_unit != want.grant_unit)
                report("grant_unit", got.grant_unit, want.grant_unit);
            if (got.class_free_count != want.class_free_count)
                report("class_free_count", got.class_free_count, want.class_free_count);
        endtask

    endclass

endpackage

>>> tb/tb_size_class_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_pool_allocator
// Self-checking testbench of the size class pool allocator. A directed run
// covers exact fits, spills, fallback and every free outcome; random runs then
// allocate and free under several size settings, one of which drains class 0
// so that its list wraps, with random gaps on input and output.
// ----------------------------------------------------------------------------
module tb_size_class_pool_allocator;

    import scpa_pkg::*;
    import alloc_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RECENT_FREES   = 32;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [SIZE_W-1:0]    request_size;
    logic [CLASS_W-1:0]   free_class;
    logic [UNIT_W-1:0]    free_unit;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [CLASS_W-1:0]   grant_class;
    logic [UNIT_W-1:0]    grant_unit;
    logic [COUNT_W-1:0]   class_free_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    pool_scoreboard  sb;
    block_handle_t   live_blocks[$];
    block_handle_t   freed_blocks[$];
    bit              steady = 1'b0;
    int              hold_off = 0;
    int              quiet_cycles = 0;

    size_class_pool_allocator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .request_size     (request_size),
        .free_class       (free_class),
        .free_unit        (free_unit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .grant_class      (grant_class),
        .grant_unit       (grant_unit),
        .class_free_count (class_free_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request sizes around the edges of the current classes
    function automatic logic [SIZE_W-1:0] pick_size();
        logic [SIZE_W-1:0] s;
        case ($urandom_range(0, 9))
            0:       s = '0;
            1:       s = '1;
            2, 3:    s = SIZE_W'($urandom);
            4, 5, 6: s = sb.block_size[$urandom_range(0, POOL_CLASSES - 1)]
                         + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
            default: s = SIZE_W'($urandom_range(1, 600));
        endcase
        return s;
    endfunction

    // allocate, free a live block, or send a malformed or stale free
    function automatic alloc_req_t next_item(int alloc_pct, int free_pct);
        alloc_req_t    req;
        block_handle_t h;
        int            roll;
        int            pick;
        roll             = $urandom_range(0, 99);
        req.mode         = MODE_ALLOC;
        req.request_size = SIZE_W'($urandom);
        req.free_class   = CLASS_W'($urandom);
        req.free_unit    = UNIT_W'($urandom);
        if (roll < alloc_pct || (roll < alloc_pct + free_pct && live_blocks.size() == 0))
            req.request_size = pick_size();
        else if (roll < alloc_pct + free_pct)
        begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            h    = live_blocks[pick];
            live_blocks.delete(pick);
            req.mode       = MODE_FREE;
            req.free_class = h.cls;
            req.free_unit  = h.unit;
        end
        else
        begin
            req.mode = MODE_FREE;
            case ($urandom_range(0, 3))
                0: req.free_class = SYS_CLASS;
                1: req.free_class = CLASS_W'(POOL_CLASSES);
                2: req.free_unit  = UNIT_W'($urandom);
                default:
                    if (freed_blocks.size() != 0)
                    begin
                        h = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
                        req.free_class = h.cls;
                        req.free_unit  = h.unit;
                    end
            endcase
        end
        return req;
    endfunction

    // one input transaction, then track the handles it gives or takes back
    task automatic send_item(alloc_req_t req);
        alloc_result_t res;
        block_handle_t h;
        int            gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= req.mode;
        request_size <= req.request_size;
        free_class   <= req.free_class;
        free_unit    <= req.free_unit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = sb.note(req);
        if (res.status == ST_GRANTED)
        begin
            h.cls  = res.grant_class;
            h.unit = res.grant_unit;
            live_blocks.push_back(h);
        end
        else if (res.status == ST_FREED)
        begin
            h.cls  = req.free_class;
            h.unit = req.free_unit;
            freed_blocks.push_back(h);
            if (freed_blocks.size() > RECENT_FREES)
                void'(freed_blocks.pop_front());
        end
    endtask

    task automatic do_alloc(int size);
        alloc_req_t req;
        req.mode         = MODE_ALLOC;
        req.request_size = SIZE_W'(size);
        req.free_class   = CLASS_W'($urandom);
        req.free_unit    = UNIT_W'($urandom);
        send_item(req);
    endtask

    task automatic do_free(int cls, int unit);
        alloc_req_t req;
        req.mode         = MODE_FREE;
        req.request_size = SIZE_W'($urandom);
        req.free_class   = CLASS_W'(cls);
        req.free_unit    = UNIT_W'(unit);
        send_item(req);
    endtask

    task automatic run_mix(int count, int alloc_pct, int free_pct);
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                steady <= ($urandom_range(0, 3) == 0);
            send_item(next_item(alloc_pct, free_pct));
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic end_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write every register index, the spare ones with random data
    task automatic load_sizes(logic [CFG_COUNT-1:0][SIZE_W-1:0] sizes);
        logic [SIZE_W-1:0] value;
        for (int i = 0; i < (1 << CFG_IDX_W); i++)
        begin
            value     = (i < CFG_COUNT) ? sizes[i] : SIZE_W'($urandom);
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_size(i, value);
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: check accepted transactions, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check({status, grant_class, grant_unit, class_free_count});
            if (steady)
                out_ready <= 1'b1;
            else if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off  <= hold_off - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    hold_off <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_ALLOC;
        request_size = '0;
        free_class   = '0;
        free_unit    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: exact fits, spill, fallback and every free outcome
        do_alloc(0);
        do_alloc(sb.block_size[0]);
        do_alloc(sb.block_size[0] + 1);
        do_alloc(sb.block_size[POOL_CLASSES - 1]);
        do_alloc(sb.block_size[POOL_CLASSES - 1] + 1);
        do_alloc(32'hFFFF);
        do_free(0, 1);
        do_free(0, 1);
        do_free(SYS_CLASS, (1 << UNIT_W) - 1);
        do_free(POOL_CLASSES, 5);
        do_free(2, (1 << UNIT_W) - 1);
        do_free(1, 0);
        do_free(POOL_CLASSES - 1, 0);
        do_alloc(1);
        do_free(0, 0);
        do_free(0, 2);
        do_free(4, 0);
        do_alloc(sb.block_size[3]);
        do_free(3, 0);
        do_alloc(sb.block_size[2] - 1);
        end_phase();

        // reset sizes, random traffic
        run_mix(400, 55, 35);
        end_phase();

        // every class at full size: drain class 0 so it wraps and spills
        load_sizes({CFG_COUNT{16'hFFFF}});
        steady <= 1'b0;
        n = 0;
        while (sb.units_left[0] != 0 && n < POOL_UNITS + 500)
        begin
            send_item(next_item(92, 5));
            n++;
        end
        run_mix(150, 50, 45);
        end_phase();

        // unordered sizes with the extremes
        load_sizes({16'd300, 16'd0, 16'd1, 16'hFFFF, 16'd100, 16'd500});
        run_mix(400, 50, 40);
        end_phase();

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
